@@ rtl/ecr_pkg.sv @@
// Shared types, widths and arc decode functions for the eight-arc circle rasterizer.
`default_nettype none

package ecr_pkg;

	// Fixed field widths
	localparam int CORNER_W = 11;
	localparam int RAD_W    = 10;
	localparam int PIX_W    = 12;

	// Walk offset from the centre, signed; covers radius plus overshoot
	localparam int DW = 13;
	// Running value of dx^2 + dy^2 - r^2, signed
	localparam int MW = 24;

	// Request queue between front and back
	localparam int QUEUE_DEPTH = 4;
	localparam int PTR_W       = $clog2(QUEUE_DEPTH);
	localparam int CNT_W       = PTR_W + 1;

	typedef enum logic {
		CMD_START = 1'b0,
		CMD_STEP  = 1'b1
	} cmd_kind_t;

	typedef enum logic [2:0] {
		ARC_LEFT_UP,
		ARC_LEFT_DOWN,
		ARC_RIGHT_UP,
		ARC_RIGHT_DOWN,
		ARC_TOP_LEFT,
		ARC_TOP_RIGHT,
		ARC_BOTTOM_LEFT,
		ARC_BOTTOM_RIGHT
	} arc_t;

	// One classified request as it sits in the queue
	typedef struct packed {
		cmd_kind_t             kind;
		logic [CORNER_W-1:0]   corner_x;
		logic [CORNER_W-1:0]   corner_y;
		logic [RAD_W-1:0]      radius;
	} cmd_t;

	// Queue head as seen by the back end
	typedef struct packed {
		logic valid;
		cmd_t cmd;
	} cmd_head_t;

	// Walk offsets at the first point of an arc
	typedef struct packed {
		logic signed [DW-1:0] dx;
		logic signed [DW-1:0] dy;
	} walk_t;

	// A unit move: which axis, and whether the offset grows
	typedef struct packed {
		logic axis_y;
		logic inc;
	} move_t;

	// First point of an arc: one axis at -r or +r, the other at the centre
	function automatic walk_t arc_start(arc_t arc, logic [RAD_W-1:0] r);
		walk_t w;
		logic signed [DW-1:0] rs;
		rs = signed'(DW'(r));
		w.dx = '0;
		w.dy = '0;
		unique case (arc)
			ARC_LEFT_UP, ARC_LEFT_DOWN:      w.dx = -rs;
			ARC_RIGHT_UP, ARC_RIGHT_DOWN:    w.dx = rs;
			ARC_TOP_LEFT, ARC_TOP_RIGHT:     w.dy = -rs;
			ARC_BOTTOM_LEFT, ARC_BOTTOM_RIGHT: w.dy = rs;
			default:                         w.dx = '0;
		endcase
		return w;
	endfunction

	// Move one unit toward the centre
	function automatic move_t move_inward(arc_t arc);
		move_t m;
		m = '0;
		unique case (arc)
			ARC_LEFT_UP, ARC_LEFT_DOWN:        m = '{axis_y: 1'b0, inc: 1'b1};
			ARC_RIGHT_UP, ARC_RIGHT_DOWN:      m = '{axis_y: 1'b0, inc: 1'b0};
			ARC_TOP_LEFT, ARC_TOP_RIGHT:       m = '{axis_y: 1'b1, inc: 1'b1};
			ARC_BOTTOM_LEFT, ARC_BOTTOM_RIGHT: m = '{axis_y: 1'b1, inc: 1'b0};
			default:                           m = '0;
		endcase
		return m;
	endfunction

	// Move one unit outward along the arc's other axis
	function automatic move_t step_outward(arc_t arc);
		move_t m;
		m = '0;
		unique case (arc)
			ARC_LEFT_UP, ARC_RIGHT_UP:       m = '{axis_y: 1'b1, inc: 1'b0};
			ARC_LEFT_DOWN, ARC_RIGHT_DOWN:   m = '{axis_y: 1'b1, inc: 1'b1};
			ARC_TOP_LEFT, ARC_BOTTOM_LEFT:   m = '{axis_y: 1'b0, inc: 1'b0};
			ARC_TOP_RIGHT, ARC_BOTTOM_RIGHT: m = '{axis_y: 1'b0, inc: 1'b1};
			default:                         m = '0;
		endcase
		return m;
	endfunction

endpackage

`default_nettype wire

@@ rtl/ecr_front.sv @@
// Front end: accepts requests, classifies them and queues them for the back end.
`default_nettype none

module ecr_front
	import ecr_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 req_valid,
	output logic                      req_ready,
	input  wire logic                 action,
	input  wire logic [CORNER_W-1:0]  corner_x,
	input  wire logic [CORNER_W-1:0]  corner_y,
	input  wire logic [RAD_W-1:0]     radius,
	output cmd_head_t                 head,
	input  wire logic                 cmd_pop
);

	cmd_t             queue_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	cmd_t             cmd_in;
	logic             push;
	logic             pop;

	// Classify the incoming request
	always_comb begin
		cmd_in.kind     = action ? CMD_STEP : CMD_START;
		cmd_in.corner_x = corner_x;
		cmd_in.corner_y = corner_y;
		cmd_in.radius   = radius;
	end

	assign req_ready  = (count_q != CNT_W'(QUEUE_DEPTH));
	assign push       = req_valid && req_ready;
	assign pop        = cmd_pop && (count_q != '0);
	assign head.valid = (count_q != '0);
	assign head.cmd   = queue_q[rd_ptr_q];

	// Queue storage
	always_ff @(posedge clk) begin
		if (push) begin
			queue_q[wr_ptr_q] <= cmd_in;
		end
	end

	// Queue pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule

`default_nettype wire

@@ rtl/ecr_back.sv @@
// Back end: arc walk engine with incremental distance tracking and result register.
`default_nettype none

module ecr_back
	import ecr_pkg::*;
#(
	parameter int COORD_BITS = 12
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire cmd_head_t         head,
	output logic                   cmd_pop,
	output logic                   res_valid,
	input  wire logic              res_ready,
	output logic                   pixel_valid,
	output logic [PIX_W-1:0]       pixel_x,
	output logic [PIX_W-1:0]       pixel_y,
	output logic                   circle_done
);

	localparam logic [PIX_W-1:0] PIX_MASK = (COORD_BITS >= PIX_W) ? {PIX_W{1'b1}} :
		PIX_W'((32'd1 << COORD_BITS) - 32'd1);

	// Circle state
	logic                   busy_q;
	arc_t                   arc_q;
	logic                   inner_q;
	logic [COORD_BITS-1:0]  cx_q;
	logic [COORD_BITS-1:0]  cy_q;
	logic [RAD_W-1:0]       r_q;
	logic signed [DW-1:0]   dx_q;
	logic signed [DW-1:0]   dy_q;
	logic signed [MW-1:0]   metric_q;

	logic signed [DW-1:0]   r_s;
	logic signed [DW-1:0]   h_s;
	logic                   outer_ok;
	logic                   bound_ok;
	logic                   inner_ok;
	logic                   emit;
	logic                   idle_adv;
	logic                   head_start;
	logic                   take;
	logic                   out_free;
	move_t                  mv;
	logic signed [DW-1:0]   d_sel;
	logic signed [DW-1:0]   d_next;
	logic signed [MW-1:0]   d_twice;
	logic signed [MW-1:0]   metric_next;
	walk_t                  start_w;
	walk_t                  next_w;
	arc_t                   arc_next;
	logic [PIX_W-1:0]       pix_x;
	logic [PIX_W-1:0]       pix_y;
	logic [CORNER_W:0]      sum_x;
	logic [CORNER_W:0]      sum_y;

	assign r_s = signed'(DW'(r_q));
	assign h_s = signed'(DW'(r_q >> 1));

	// Outer and inner loop conditions of the current arc
	always_comb begin
		outer_ok = 1'b0;
		bound_ok = 1'b0;
		unique case (arc_q)
			ARC_LEFT_UP: begin
				outer_ok = (dx_q < 0) && (dy_q > -h_s);
				bound_ok = (dx_q < 0);
			end
			ARC_LEFT_DOWN: begin
				outer_ok = (dx_q < 0) && (dy_q < h_s);
				bound_ok = (dx_q < 0);
			end
			ARC_RIGHT_UP: begin
				outer_ok = (dx_q > 0) && (dy_q > -h_s);
				bound_ok = (dx_q > 0);
			end
			ARC_RIGHT_DOWN: begin
				outer_ok = (dx_q > 0) && (dy_q < h_s);
				bound_ok = (dx_q >= 0);
			end
			ARC_TOP_LEFT: begin
				outer_ok = (dx_q > -r_s) && (dy_q < -h_s);
				bound_ok = (dy_q < -h_s);
			end
			ARC_TOP_RIGHT: begin
				outer_ok = (dx_q < r_s) && (dy_q < -h_s);
				bound_ok = (dy_q < -h_s);
			end
			ARC_BOTTOM_LEFT: begin
				outer_ok = (dx_q > -r_s) && (dy_q > h_s);
				bound_ok = (dy_q > h_s);
			end
			ARC_BOTTOM_RIGHT: begin
				outer_ok = (dx_q < r_s) && (dy_q > h_s);
				bound_ok = (dy_q > h_s);
			end
			default: begin
				outer_ok = 1'b0;
				bound_ok = 1'b0;
			end
		endcase
	end

	assign inner_ok = (metric_q >= signed'(MW'(r_q))) && bound_ok;

	// Control: a step request waits while the result is held or the arc advances
	assign emit       = busy_q && (inner_q || outer_ok);
	assign idle_adv   = busy_q && !inner_q && !outer_ok && (arc_q != ARC_BOTTOM_RIGHT);
	assign head_start = head.valid && (head.cmd.kind == CMD_START);
	assign out_free   = !res_valid || res_ready;
	assign take       = head.valid && out_free && (head_start || !idle_adv);
	assign cmd_pop    = take;

	// Unit move; dx^2 changes by 2dx+1 going up and by 1-2dx going down
	always_comb begin
		mv          = inner_ok ? move_inward(arc_q) : step_outward(arc_q);
		d_sel       = mv.axis_y ? dy_q : dx_q;
		d_twice     = MW'(d_sel) <<< 1;
		d_next      = mv.inc ? d_sel + DW'(1) : d_sel - DW'(1);
		metric_next = mv.inc ? metric_q + d_twice + MW'(1) : metric_q - d_twice + MW'(1);
	end

	// Start point of a new circle and of the next arc
	assign start_w  = arc_start(ARC_LEFT_UP, head.cmd.radius);
	assign arc_next = arc_t'(arc_q + 3'd1);
	assign next_w   = arc_start(arc_next, r_q);
	assign sum_x    = {1'b0, head.cmd.corner_x} + (CORNER_W + 1)'(head.cmd.radius);
	assign sum_y    = {1'b0, head.cmd.corner_y} + (CORNER_W + 1)'(head.cmd.radius);

	// Pixel coordinates wrap to the coordinate field
	assign pix_x = (PIX_W'(cx_q) + PIX_W'(dx_q)) & PIX_MASK;
	assign pix_y = (PIX_W'(cy_q) + PIX_W'(dy_q)) & PIX_MASK;

	// Walk state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q   <= 1'b0;
			arc_q    <= ARC_LEFT_UP;
			inner_q  <= 1'b0;
			cx_q     <= '0;
			cy_q     <= '0;
			r_q      <= '0;
			dx_q     <= '0;
			dy_q     <= '0;
			metric_q <= '0;
		end else if (take && head_start) begin
			busy_q   <= 1'b1;
			arc_q    <= ARC_LEFT_UP;
			inner_q  <= 1'b0;
			r_q      <= head.cmd.radius;
			cx_q     <= COORD_BITS'(sum_x);
			cy_q     <= COORD_BITS'(sum_y);
			dx_q     <= start_w.dx;
			dy_q     <= start_w.dy;
			metric_q <= '0;
		end else if (take && emit) begin
			inner_q  <= inner_ok;
			metric_q <= metric_next;
			if (mv.axis_y) begin
				dy_q <= d_next;
			end else begin
				dx_q <= d_next;
			end
		end else if (take && busy_q) begin
			// last arc exhausted
			busy_q <= 1'b0;
			arc_q  <= ARC_LEFT_UP;
		end else if (idle_adv) begin
			arc_q    <= arc_next;
			inner_q  <= 1'b0;
			dx_q     <= next_w.dx;
			dy_q     <= next_w.dy;
			metric_q <= '0;
		end
	end

	// Result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid <= 1'b0;
		end else if (take) begin
			res_valid <= 1'b1;
		end else if (res_ready) begin
			res_valid <= 1'b0;
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (take) begin
			pixel_valid <= !head_start && emit;
			pixel_x     <= (!head_start && emit) ? pix_x : '0;
			pixel_y     <= (!head_start && emit) ? pix_y : '0;
			circle_done <= !head_start && busy_q && !emit;
		end
	end

endmodule

`default_nettype wire

@@ rtl/eight_arc_circle_rasterizer.sv @@
// Top level of the eight-arc circle rasterizer: request queue front end and arc walk back end.
//
//  channel  | handshake             | payload
//  ---------+-----------------------+----------------------------------------------
//  request  | req_valid / req_ready | action, corner_x, corner_y, radius
//  result   | res_valid / res_ready | pixel_valid, pixel_x, pixel_y, circle_done
//
// Every request gives exactly one result; requests and results flow at one per cycle
// while the result register is free and the engine is not moving to the next arc.
// Each move to the next arc, empty or traced, is a walk register update in which no step
// request is taken; it is spent while the engine waits for a step request or stalls
// the head step.
// A request reaches the back end through a four-entry queue that registers it on acceptance.
// Reset clears the queue and the walk state; the block is idle afterwards.
// res_ready low holds the result register; the queue keeps taking requests until full.
`default_nettype none

module eight_arc_circle_rasterizer
	import ecr_pkg::*;
#(
	parameter int COORD_BITS = 12
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 req_valid,
	output logic                      req_ready,
	input  wire logic                 action,
	input  wire logic [CORNER_W-1:0]  corner_x,
	input  wire logic [CORNER_W-1:0]  corner_y,
	input  wire logic [RAD_W-1:0]     radius,
	output logic                      res_valid,
	input  wire logic                 res_ready,
	output logic                      pixel_valid,
	output logic [PIX_W-1:0]          pixel_x,
	output logic [PIX_W-1:0]          pixel_y,
	output logic                      circle_done
);

	cmd_head_t head;
	logic      cmd_pop;

	ecr_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.action    (action),
		.corner_x  (corner_x),
		.corner_y  (corner_y),
		.radius    (radius),
		.head      (head),
		.cmd_pop   (cmd_pop)
	);

	ecr_back #(
		.COORD_BITS (COORD_BITS)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head        (head),
		.cmd_pop     (cmd_pop),
		.res_valid   (res_valid),
		.res_ready   (res_ready),
		.pixel_valid (pixel_valid),
		.pixel_x     (pixel_x),
		.pixel_y     (pixel_y),
		.circle_done (circle_done)
	);

	// A result never carries a pixel and the end mark together
	a_done_no_pixel: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> !(pixel_valid && circle_done))
		else $error("result carries both a pixel and circle_done");

	// A result without a pixel has zero coordinates
	a_blank_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && !pixel_valid) |-> (pixel_x == '0) && (pixel_y == '0))
		else $error("blank result with nonzero coordinates");

	// After a request is accepted, the queue head is valid on the next cycle
	a_queue_fill: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && req_ready) |=> head.valid)
		else $error("accepted request missing from queue");

	// The back end only pops a request that is present
	a_pop_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_pop |-> head.valid)
		else $error("pop of an empty queue");

endmodule

`default_nettype wire
